@@ design/spg_pkg.sv @@
// ----------------------------------------------------------------------------
// spg_pkg: shared types and constants of the slotted page store
// Holds the page geometry, the request classes, the status codes and the
// structs that travel between the front and the back part.
// ----------------------------------------------------------------------------
package spg_pkg;

    localparam int PAGE_BYTES = 1024;
    localparam int MEM_AW     = $clog2(PAGE_BYTES);
    localparam int ADDR_W     = 18;

    localparam logic [1:0] CMD_ADD  = 2'd0;
    localparam logic [1:0] CMD_DEL  = 2'd1;
    localparam logic [1:0] CMD_READ = 2'd2;

    localparam logic [1:0] CLS_ADD  = 2'd0;
    localparam logic [1:0] CLS_DEL  = 2'd1;
    localparam logic [1:0] CLS_READ = 2'd2;
    localparam logic [1:0] CLS_NOP  = 2'd3;

    localparam logic [2:0] ST_DONE    = 3'd0;
    localparam logic [2:0] ST_PENDING = 3'd1;
    localparam logic [2:0] ST_NOROOM  = 3'd2;
    localparam logic [2:0] ST_BADIDX  = 3'd3;
    localparam logic [2:0] ST_BADOFF  = 3'd4;

    typedef struct packed {
        logic [1:0]  cls;
        logic [8:0]  slot_index;
        logic [9:0]  byte_offset;
        logic [10:0] item_length;
        logic [7:0]  data_byte;
        logic        last_byte;
    } spg_req_t;

    typedef struct packed {
        logic     vld;
        spg_req_t req;
    } spg_head_t;

    typedef struct packed {
        logic clearing;
        logic pop;
    } spg_bstat_t;

endpackage

@@ design/spg_front.sv @@
// ----------------------------------------------------------------------------
// spg_front: request intake
// Accepts requests, classifies the command and holds them in a two-entry
// queue until the back part takes them.
// ----------------------------------------------------------------------------
module spg_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [39:0]       s_tdata,
    input  logic [1:0]        s_tuser,
    input  logic              s_tlast,
    input  spg_pkg::spg_bstat_t bstat,
    output spg_pkg::spg_head_t  head
);
    import spg_pkg::*;

    spg_req_t   q_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    spg_req_t   in_req;
    logic       push;

    always_comb begin
        in_req.slot_index  = s_tdata[8:0];
        in_req.byte_offset = s_tdata[18:9];
        in_req.item_length = s_tdata[29:19];
        in_req.data_byte   = s_tdata[37:30];
        in_req.last_byte   = s_tlast;
        case (s_tuser)
            CMD_ADD:  in_req.cls = CLS_ADD;
            CMD_DEL:  in_req.cls = CLS_DEL;
            CMD_READ: in_req.cls = CLS_READ;
            default:  in_req.cls = CLS_NOP;
        endcase
    end

    assign s_tready = (cnt_reg != 2'd2) && !bstat.clearing;
    assign push     = s_tvalid && s_tready;
    assign head.vld = (cnt_reg != 2'd0);
    assign head.req = q_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= in_req;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (bstat.pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(bstat.pop);
        end
    end

endmodule

@@ design/spg_back.sv @@
// ----------------------------------------------------------------------------
// spg_back: page sequencer
// Owns the page memory and carries out adds, deletes and reads with at most one memory
// access per cycle, then hands the result to the output register.
// ----------------------------------------------------------------------------
module spg_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  spg_pkg::spg_head_t  head,
    output spg_pkg::spg_bstat_t bstat,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [39:0]       m_tdata,
    output logic [2:0]        m_tuser
);
    import spg_pkg::*;

    localparam logic [4:0] S_CLR    = 5'd0;
    localparam logic [4:0] S_IDLE   = 5'd1;
    localparam logic [4:0] S_WR0    = 5'd2;
    localparam logic [4:0] S_WR1    = 5'd3;
    localparam logic [4:0] S_WR2    = 5'd4;
    localparam logic [4:0] S_WW0    = 5'd5;
    localparam logic [4:0] S_WW1    = 5'd6;
    localparam logic [4:0] S_ADDCHK = 5'd7;
    localparam logic [4:0] S_ADDB   = 5'd8;
    localparam logic [4:0] S_ADDC   = 5'd9;
    localparam logic [4:0] S_RD1    = 5'd10;
    localparam logic [4:0] S_RD2    = 5'd11;
    localparam logic [4:0] S_RD3    = 5'd12;
    localparam logic [4:0] S_DL1    = 5'd13;
    localparam logic [4:0] S_DL2    = 5'd14;
    localparam logic [4:0] S_DL3    = 5'd15;
    localparam logic [4:0] S_MV0    = 5'd16;
    localparam logic [4:0] S_MV1    = 5'd17;
    localparam logic [4:0] S_MV2    = 5'd18;
    localparam logic [4:0] S_AJ0    = 5'd19;
    localparam logic [4:0] S_AJ1    = 5'd20;
    localparam logic [4:0] S_DLE    = 5'd21;
    localparam logic [4:0] S_DLF    = 5'd22;
    localparam logic [4:0] S_OUT    = 5'd23;

    localparam logic [15:0]     PAGE_W   = 16'(PAGE_BYTES);
    localparam logic [ADDR_W-1:0] PAGE_A = ADDR_W'(PAGE_BYTES);
    localparam logic [MEM_AW-1:0] CLR_END = MEM_AW'(PAGE_BYTES - 1);

    logic [7:0]        mem [PAGE_BYTES];
    logic [7:0]        rdata_reg;
    logic              rin_reg;
    logic [7:0]        rdata;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [7:0]        mem_wdata;
    logic [ADDR_W-1:0] mem_raddr;

    logic [4:0]        state_reg;
    logic [4:0]        ret_reg;
    logic [MEM_AW-1:0] clr_reg;
    spg_req_t          it_reg;
    logic [15:0]       count_reg;
    logic [16:0]       wk_reg;
    logic [7:0]        lo_reg;
    logic [15:0]       wv_reg;
    logic [16:0]       wwk_reg;
    logic [15:0]       wwv_reg;
    logic              add_act_reg;
    logic              add_rej_reg;
    logic [15:0]       add_base_reg;
    logic [10:0]       add_wr_reg;
    logic [15:0]       add_end_reg;
    logic [15:0]       d_reg;
    logic [15:0]       p_reg;
    logic [15:0]       bot_reg;
    logic [15:0]       gap_reg;
    logic [16:0]       k_reg;
    logic [2:0]        res_status_reg;
    logic [8:0]        res_idx_reg;
    logic [7:0]        res_byte_reg;
    logic [10:0]       res_size_reg;
    logic              ov_reg;
    logic [2:0]        o_status_reg;
    logic [36:0]       o_data_reg;

    logic [18:0]       st_start;
    logic [18:0]       st_limit;
    logic              room_bad;
    logic [16:0]       add_pos;
    logic [15:0]       rd_size;
    logic              mv_go;
    logic              out_free;

    assign rdata    = rin_reg ? rdata_reg : 8'd0;
    assign st_start = 19'(wv_reg) - 19'(it_reg.item_length);
    assign st_limit = 19'({count_reg, 1'b0}) + 19'd4;
    assign room_bad = $signed(st_start) <= $signed(st_limit);
    assign add_pos  = 17'(add_base_reg) + 17'(add_wr_reg);
    assign rd_size  = wv_reg - d_reg;
    assign mv_go    = (p_reg > d_reg) && (d_reg > bot_reg) && (p_reg != 16'd0);
    assign out_free = !ov_reg || m_tready;

    assign bstat.clearing = (state_reg == S_CLR);
    assign bstat.pop      = (state_reg == S_IDLE) && head.vld;

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = 8'd0;
        mem_raddr = '0;
        case (state_reg)
            S_CLR: begin
                mem_we    = 1'b1;
                mem_waddr = ADDR_W'(clr_reg);
            end
            S_WR0: mem_raddr = {wk_reg, 1'b0};
            S_WR1: mem_raddr = {wk_reg, 1'b1};
            S_WW0: begin
                mem_we    = 1'b1;
                mem_waddr = {wwk_reg, 1'b0};
                mem_wdata = wwv_reg[7:0];
            end
            S_WW1: begin
                mem_we    = 1'b1;
                mem_waddr = {wwk_reg, 1'b1};
                mem_wdata = wwv_reg[15:8];
            end
            S_ADDB: begin
                mem_we    = !add_rej_reg && (add_pos < 17'(add_end_reg));
                mem_waddr = ADDR_W'(add_pos);
                mem_wdata = it_reg.data_byte;
            end
            S_RD2: mem_raddr = ADDR_W'(17'(d_reg) + 17'(it_reg.byte_offset));
            S_MV0: mem_raddr = ADDR_W'(d_reg - 16'd1);
            S_MV1: begin
                mem_we    = 1'b1;
                mem_waddr = ADDR_W'(p_reg);
                mem_wdata = rdata;
            end
            S_MV2: begin
                mem_we    = 1'b1;
                mem_waddr = ADDR_W'(d_reg);
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    // Bytes at or beyond the page end read as zero and ignore writes.
    always_ff @(posedge aclk) begin
        if (mem_we && (mem_waddr < PAGE_A)) begin
            mem[mem_waddr[MEM_AW-1:0]] <= mem_wdata;
        end
        rdata_reg <= mem[mem_raddr[MEM_AW-1:0]];
        rin_reg   <= mem_raddr < PAGE_A;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLR;
            ret_reg     <= S_IDLE;
            clr_reg     <= '0;
            count_reg   <= 16'd0;
            add_act_reg <= 1'b0;
            add_rej_reg <= 1'b0;
            ov_reg      <= 1'b0;
        end else begin
            // In S_OUT the output register is reloaded instead.
            if (ov_reg && m_tready && (state_reg != S_OUT)) begin
                ov_reg <= 1'b0;
            end
            case (state_reg)
                S_CLR: begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == CLR_END) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (head.vld) begin
                        it_reg         <= head.req;
                        res_status_reg <= ST_DONE;
                        res_idx_reg    <= 9'd0;
                        res_byte_reg   <= 8'd0;
                        res_size_reg   <= 11'd0;
                        case (head.req.cls)
                            CLS_ADD: begin
                                if (add_act_reg) begin
                                    state_reg <= S_ADDB;
                                end else if (count_reg == 16'd0) begin
                                    wv_reg    <= PAGE_W;
                                    state_reg <= S_ADDCHK;
                                end else begin
                                    wk_reg    <= 17'(count_reg);
                                    ret_reg   <= S_ADDCHK;
                                    state_reg <= S_WR0;
                                end
                            end
                            CLS_DEL, CLS_READ: begin
                                add_act_reg <= 1'b0;
                                add_rej_reg <= 1'b0;
                                if (16'(head.req.slot_index) >= count_reg) begin
                                    res_status_reg <= ST_BADIDX;
                                    state_reg      <= S_OUT;
                                end else begin
                                    wk_reg    <= 17'(head.req.slot_index) + 17'd1;
                                    ret_reg   <= (head.req.cls == CLS_DEL) ? S_DL1 : S_RD1;
                                    state_reg <= S_WR0;
                                end
                            end
                            default: begin
                                add_act_reg <= 1'b0;
                                add_rej_reg <= 1'b0;
                                state_reg   <= S_OUT;
                            end
                        endcase
                    end
                end
                S_WR0: state_reg <= S_WR1;
                S_WR1: begin
                    lo_reg    <= rdata;
                    state_reg <= S_WR2;
                end
                S_WR2: begin
                    wv_reg    <= {rdata, lo_reg};
                    state_reg <= ret_reg;
                end
                S_WW0: state_reg <= S_WW1;
                S_WW1: state_reg <= ret_reg;
                S_ADDCHK: begin
                    add_act_reg  <= 1'b1;
                    add_wr_reg   <= 11'd0;
                    add_rej_reg  <= room_bad;
                    add_base_reg <= room_bad ? 16'd0 : st_start[15:0];
                    add_end_reg  <= wv_reg;
                    state_reg    <= S_ADDB;
                end
                S_ADDB: begin
                    if (it_reg.last_byte) begin
                        add_act_reg <= 1'b0;
                        add_rej_reg <= 1'b0;
                    end
                    if (add_rej_reg) begin
                        res_status_reg <= ST_NOROOM;
                        state_reg      <= S_OUT;
                    end else begin
                        if (add_pos < 17'(add_end_reg)) begin
                            add_wr_reg <= add_wr_reg + 11'd1;
                        end
                        if (it_reg.last_byte) begin
                            wwk_reg   <= 17'(count_reg) + 17'd1;
                            wwv_reg   <= add_base_reg;
                            ret_reg   <= S_ADDC;
                            state_reg <= S_WW0;
                        end else begin
                            res_status_reg <= ST_PENDING;
                            state_reg      <= S_OUT;
                        end
                    end
                end
                S_ADDC: begin
                    count_reg   <= count_reg + 16'd1;
                    res_idx_reg <= count_reg[8:0];
                    wwk_reg     <= 17'd0;
                    wwv_reg     <= count_reg + 16'd1;
                    ret_reg     <= S_OUT;
                    state_reg   <= S_WW0;
                end
                S_RD1, S_DL1: begin
                    d_reg <= wv_reg;
                    if (it_reg.slot_index != 9'd0) begin
                        wk_reg    <= 17'(it_reg.slot_index);
                        ret_reg   <= (state_reg == S_DL1) ? S_DL2 : S_RD2;
                        state_reg <= S_WR0;
                    end else begin
                        wv_reg    <= PAGE_W;
                        state_reg <= (state_reg == S_DL1) ? S_DL2 : S_RD2;
                    end
                end
                S_RD2: begin
                    res_size_reg <= rd_size[10:0];
                    if (16'(it_reg.byte_offset) >= rd_size) begin
                        res_status_reg <= ST_BADOFF;
                        state_reg      <= S_OUT;
                    end else begin
                        state_reg <= S_RD3;
                    end
                end
                S_RD3: begin
                    res_byte_reg <= rdata;
                    state_reg    <= S_OUT;
                end
                S_DL2: begin
                    p_reg     <= wv_reg;
                    wk_reg    <= 17'(count_reg);
                    ret_reg   <= S_DL3;
                    state_reg <= S_WR0;
                end
                S_DL3: begin
                    bot_reg   <= wv_reg;
                    state_reg <= S_MV0;
                end
                // Each moved byte takes a read, a write to its new place and a
                // zero write to the place it left.
                S_MV0: begin
                    if (mv_go) begin
                        d_reg     <= d_reg - 16'd1;
                        p_reg     <= p_reg - 16'd1;
                        state_reg <= S_MV1;
                    end else begin
                        gap_reg   <= p_reg - d_reg;
                        k_reg     <= 17'(it_reg.slot_index) + 17'd1;
                        state_reg <= S_AJ0;
                    end
                end
                S_MV1: state_reg <= S_MV2;
                S_MV2: state_reg <= S_MV0;
                S_AJ0: begin
                    if (k_reg < 17'(count_reg)) begin
                        wk_reg    <= k_reg + 17'd1;
                        ret_reg   <= S_AJ1;
                        state_reg <= S_WR0;
                    end else begin
                        state_reg <= S_DLE;
                    end
                end
                S_AJ1: begin
                    wwk_reg   <= k_reg;
                    wwv_reg   <= wv_reg + gap_reg;
                    k_reg     <= k_reg + 17'd1;
                    ret_reg   <= S_AJ0;
                    state_reg <= S_WW0;
                end
                S_DLE: begin
                    count_reg <= count_reg - 16'd1;
                    wwk_reg   <= 17'd0;
                    wwv_reg   <= count_reg - 16'd1;
                    ret_reg   <= S_DLF;
                    state_reg <= S_WW0;
                end
                S_DLF: begin
                    wwk_reg   <= 17'(count_reg) + 17'd1;
                    wwv_reg   <= 16'd0;
                    ret_reg   <= S_OUT;
                    state_reg <= S_WW0;
                end
                S_OUT: begin
                    if (out_free) begin
                        ov_reg       <= 1'b1;
                        o_status_reg <= res_status_reg;
                        o_data_reg   <= {count_reg[8:0], res_size_reg,
                                         res_byte_reg, res_idx_reg};
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_tvalid = ov_reg;
    assign m_tuser  = o_status_reg;
    assign m_tdata  = {3'd0, o_data_reg};

    a_out_from_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(ov_reg) |-> $past(state_reg) == S_OUT)
        else $error("result appeared without a finished request");

    a_rej_in_add: assert property (@(posedge aclk) disable iff (!aresetn)
        add_rej_reg |-> add_act_reg)
        else $error("rejected add flag set outside an add");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && (count_reg != $past(count_reg)) |->
            (count_reg == $past(count_reg) + 16'd1) ||
            (count_reg == $past(count_reg) - 16'd1))
        else $error("item count changed by more than one");

endmodule

@@ design/slotted_page_store.sv @@
// One request is worked on at a time and two more queue; a result that waits for m_tready
// holds the sequencer.
// Reset: synchronous, active low; afterwards a clearing pass zeroes the page, and no
// request is accepted until it ends.
// ----------------------------------------------------------------------------
// slotted_page_store: top level
// One page with an item count, an offset table and data packed from the end.
// ----------------------------------------------------------------------------
module slotted_page_store (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // slot_index[8:0], byte_offset[18:9], item_length[29:19], data_byte[37:30]
    input  logic [39:0] s_tdata,
    // cmd[1:0]
    input  logic [1:0]  s_tuser,
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    // result_index[8:0], read_byte[16:9], item_size[27:17], item_count[36:28]
    output logic [39:0] m_tdata,
    // status[2:0]
    output logic [2:0]  m_tuser
);
    import spg_pkg::*;

    spg_head_t  head;
    spg_bstat_t bstat;

    spg_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .bstat    (bstat),
        .head     (head)
    );

    spg_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .bstat    (bstat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule
